[hw/rtl/nv12d_pkg.sv]
// Shared types and constants for the NV12 tiled-to-linear address generator.
`default_nettype none

package nv12d_pkg;

    localparam int unsigned DIM_W       = 13;
    localparam int unsigned STRIDE_W    = 14;
    localparam int unsigned ROW_W       = 12;
    localparam int unsigned CHUNK_W     = 6;
    localparam int unsigned OFFSET_W    = 25;
    localparam int unsigned COUNT_W     = 7;
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 14;

    // One chunk is 64 bytes wide, one tile is 64 x 32 bytes.
    localparam int unsigned CHUNK_SHIFT     = 6;
    localparam int unsigned TILE_ROW_SHIFT  = 5;
    localparam int unsigned TILE_SHIFT      = 11;
    localparam int unsigned CHROMA_SHIFT    = 13;
    localparam logic [COUNT_W-1:0] CHUNK_BYTES = 7'd64;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_FRAME_WIDTH   = 2'd0,
        CFG_FRAME_HEIGHT  = 2'd1,
        CFG_LUMA_STRIDE   = 2'd2,
        CFG_CHROMA_STRIDE = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic               plane_sel;
        logic [CHUNK_W-1:0] chunk_index;
        logic [ROW_W-1:0]   row_index;
    } chunk_req_t;

    // Packed from the lowest bit up: source_offset, dest_offset, byte_count.
    typedef struct packed {
        logic [COUNT_W-1:0]  byte_count;
        logic [OFFSET_W-1:0] dest_offset;
        logic [OFFSET_W-1:0] source_offset;
    } chunk_addr_t;

endpackage

`default_nettype wire

[hw/rtl/nv12_tiled_detile_address.sv]
// Top level of the NV12 64x32-tile detiling address generator.
`default_nettype none

// Takes one chunk request per cycle while not stalled (plane, row, 64-byte chunk)
// and returns the chunk's byte offset in the 64x32-tiled source buffer, its offset
// in the linear destination plane, its byte count and an in-range flag. A request
// is latched in an input register; the tile index, the row times stride product
// and the chroma base are formed in one pass of logic from there into the result
// register, so a full rate of one item per clock is sustained while m_tready is
// high. The result register lets a new item enter while a finished one still waits
// on m_tready. Frame size and line strides come from the write port and are written
// by the user only while no item is in flight; the block does not enforce this.
module nv12_tiled_detile_address #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [13:0] cfg_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,  // row_index[11:0], chunk_index[17:12], zero pad
    input  wire logic        s_tuser,  // plane_sel
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,  // source_offset[24:0], dest_offset[49:25],
                                       // byte_count[56:50], zero pad
    output logic             m_tuser   // in_range
);

    localparam logic [nv12d_pkg::DIM_W:0] MaxW = 14'(MAX_WIDTH);
    localparam logic [nv12d_pkg::DIM_W:0] MaxH = 14'(MAX_HEIGHT);

    // Configuration registers.
    logic [nv12d_pkg::DIM_W-1:0]    frame_width_reg;
    logic [nv12d_pkg::DIM_W-1:0]    frame_height_reg;
    logic [nv12d_pkg::STRIDE_W-1:0] luma_stride_reg;
    logic [nv12d_pkg::STRIDE_W-1:0] chroma_stride_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg   <= 13'd64;
            frame_height_reg  <= 13'd32;
            luma_stride_reg   <= 14'd64;
            chroma_stride_reg <= 14'd64;
        end
        else if (cfg_we)
        begin
            unique case (nv12d_pkg::cfg_index_t'(cfg_index))
                nv12d_pkg::CFG_FRAME_WIDTH:   frame_width_reg   <= cfg_data[12:0];
                nv12d_pkg::CFG_FRAME_HEIGHT:  frame_height_reg  <= cfg_data[12:0];
                nv12d_pkg::CFG_LUMA_STRIDE:   luma_stride_reg   <= cfg_data;
                nv12d_pkg::CFG_CHROMA_STRIDE: chroma_stride_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Handshake: input register feeds the result register.
    logic                  req_valid_reg;
    nv12d_pkg::chunk_req_t req_reg;
    logic                  out_valid_reg;
    nv12d_pkg::chunk_addr_t out_addr_reg;
    logic                  out_in_range_reg;
    logic                  out_load;
    logic                  in_load;

    assign out_load = !out_valid_reg || m_tready;
    assign s_tready = !req_valid_reg || out_load;
    assign in_load  = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                req_valid_reg <= s_tvalid;
            end
            if (out_load)
            begin
                out_valid_reg <= req_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            req_reg.plane_sel   <= s_tuser;
            req_reg.row_index   <= s_tdata[11:0];
            req_reg.chunk_index <= s_tdata[17:12];
        end
    end

    // Frame geometry, clamped to the supported maximum.
    logic [12:0] w;
    logic [12:0] h;
    logic [7:0]  w_tiles;
    logic [8:0]  cols_sum;
    logic [7:0]  cols;
    logic [8:0]  luma_rows;
    logic [16:0] luma_tiles;
    logic [17:0] luma_tiles_rnd;
    logic [24:0] luma_bytes;

    always_comb
    begin
        w = ({1'b0, frame_width_reg} > MaxW) ? MaxW[12:0] : frame_width_reg;
        h = ({1'b0, frame_height_reg} > MaxH) ? MaxH[12:0] : frame_height_reg;
        w_tiles   = 8'(({1'b0, w} + 14'd63) >> nv12d_pkg::CHUNK_SHIFT);
        cols_sum  = {1'b0, w_tiles} + 9'd1;
        cols      = {cols_sum[7:1], 1'b0};
        luma_rows = 9'(({1'b0, h} + 14'd31) >> nv12d_pkg::TILE_ROW_SHIFT);
        luma_tiles = 17'(cols) * 17'(luma_rows);
        // Rounding the tile count up to a multiple of four puts chroma on 8 KiB.
        luma_tiles_rnd = {1'b0, luma_tiles} + 18'd3;
        luma_bytes = {luma_tiles_rnd[13:2], 13'd0};
    end

    // Per-request address logic.
    logic [13:0] pw;
    logic [12:0] ph;
    logic [13:0] stride;
    logic [11:0] x;
    logic        in_range;
    logic [8:0]  prow_tiles;
    logic [6:0]  ty;
    logic [14:0] pair_base;
    logic [6:0]  zig_adj;
    logic [6:0]  tx_plus2;
    logic        last_odd_row;
    logic [15:0] tile_idx;
    logic [24:0] src;
    logic [25:0] row_prod;
    logic [24:0] dest;
    logic [13:0] left;
    logic [6:0]  count;
    nv12d_pkg::chunk_addr_t addr_next;

    always_comb
    begin
        if (req_reg.plane_sel)
        begin
            pw     = ({1'b0, w} + 14'd1) & ~14'd1;
            ph     = 13'(({1'b0, h} + 14'd1) >> 1);
            stride = chroma_stride_reg;
        end
        else
        begin
            pw     = {1'b0, w};
            ph     = h;
            stride = luma_stride_reg;
        end

        x = {req_reg.chunk_index, 6'd0};
        in_range = ({1'b0, req_reg.row_index} < ph) && ({2'b00, x} < pw);

        prow_tiles = 9'(({1'b0, ph} + 14'd31) >> nv12d_pkg::TILE_ROW_SHIFT);
        ty         = req_reg.row_index[11:5];
        pair_base  = 15'({ty[6:1], 1'b0}) * 15'(cols);
        tx_plus2   = {1'b0, req_reg.chunk_index} + 7'd2;
        // A lone last tile row of odd count is stored linearly, with no zig-zag.
        last_odd_row = prow_tiles[0] && (({2'b00, ty} + 9'd1) == prow_tiles);

        if (ty[0])
        begin
            zig_adj = {1'b0, req_reg.chunk_index[5:2], 2'b00} + 7'd2;
        end
        else if (!last_odd_row)
        begin
            zig_adj = {tx_plus2[6:2], 2'b00};
        end
        else
        begin
            zig_adj = 7'd0;
        end

        tile_idx = 16'(pair_base) + 16'(req_reg.chunk_index) + 16'(zig_adj);
        src = {tile_idx[13:0], 11'd0}
            + {14'd0, req_reg.row_index[4:0], 6'd0}
            + (req_reg.plane_sel ? luma_bytes : 25'd0);

        row_prod = 26'(req_reg.row_index) * 26'(stride);
        dest     = row_prod[24:0] + 25'(x);

        left  = pw - {2'b00, x};
        count = (left < 14'(nv12d_pkg::CHUNK_BYTES)) ? left[6:0] : nv12d_pkg::CHUNK_BYTES;

        if (in_range)
        begin
            addr_next.source_offset = src;
            addr_next.dest_offset   = dest;
            addr_next.byte_count    = count;
        end
        else
        begin
            addr_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load && req_valid_reg)
        begin
            out_addr_reg     <= addr_next;
            out_in_range_reg <= in_range;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_addr_reg};
    assign m_tuser  = out_in_range_reg;

    // An item out of the plane carries all-zero offsets and count.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata == 64'd0)
        else $error("out-of-range item has nonzero payload");

    // An item in the plane copies between 1 and 64 bytes.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> (m_tdata[56:50] != 7'd0) && (m_tdata[56:50] <= 7'd64))
        else $error("in-range item has bad byte count");

    // A held request is not dropped while the result register is stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid_reg && !out_load |=> req_valid_reg && $stable(req_reg))
        else $error("stalled request lost");

    // An accepted item always lands in the input register.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_load |=> req_valid_reg)
        else $error("accepted item not held");

endmodule

`default_nettype wire

[tb/sv/testbench.sv]
// Self-checking testbench for the NV12 tiled-to-linear chunk address generator.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned FRAME_MAX_W = 4096;
    localparam int unsigned FRAME_MAX_H = 4096;
    localparam int unsigned STALL_LIMIT = 4000;
    localparam int unsigned PHASE_COUNT = 14;
    localparam int unsigned PHASE_ITEMS = 118;

    typedef struct {
        logic [nv12d_pkg::OFFSET_W-1:0] source_offset;
        logic [nv12d_pkg::OFFSET_W-1:0] dest_offset;
        logic [nv12d_pkg::COUNT_W-1:0]  byte_count;
        logic                           in_range;
    } chunk_result_t;

    class chunk_scoreboard;
        int unsigned   frame_width;
        int unsigned   frame_height;
        int unsigned   luma_stride;
        int unsigned   chroma_stride;
        chunk_result_t expected_q[$];
        int unsigned   errors;

        function new();
            frame_width   = 64;
            frame_height  = 32;
            luma_stride   = 64;
            chroma_stride = 64;
            errors        = 0;
        endfunction

        function void write_reg(nv12d_pkg::cfg_index_t idx,
                                logic [nv12d_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                nv12d_pkg::CFG_FRAME_WIDTH:   frame_width   = data[nv12d_pkg::DIM_W-1:0];
                nv12d_pkg::CFG_FRAME_HEIGHT:  frame_height  = data[nv12d_pkg::DIM_W-1:0];
                nv12d_pkg::CFG_LUMA_STRIDE:   luma_stride   = data;
                nv12d_pkg::CFG_CHROMA_STRIDE: chroma_stride = data;
                default: ;
            endcase
        endfunction

        function int unsigned luma_width();
            return (frame_width > FRAME_MAX_W) ? FRAME_MAX_W : frame_width;
        endfunction

        function int unsigned luma_height();
            return (frame_height > FRAME_MAX_H) ? FRAME_MAX_H : frame_height;
        endfunction

        // Chroma rows are interleaved Cb/Cr pairs, so the byte width rounds up to even.
        function int unsigned plane_width(logic plane);
            return plane ? ((luma_width() + 1) / 2) * 2 : luma_width();
        endfunction

        function int unsigned plane_height(logic plane);
            return plane ? (luma_height() + 1) / 2 : luma_height();
        endfunction

        function chunk_result_t chunk_address(logic plane, logic [nv12d_pkg::ROW_W-1:0] row,
                                              logic [nv12d_pkg::CHUNK_W-1:0] chunk);
            longint unsigned tile_cols;
            longint unsigned chroma_base;
            longint unsigned pw;
            longint unsigned ph;
            longint unsigned stride;
            longint unsigned x;
            longint unsigned plane_tile_rows;
            longint unsigned tx;
            longint unsigned ty;
            longint unsigned tile;
            longint unsigned src;
            longint unsigned dst;
            longint unsigned left;
            chunk_result_t   res;

            res.source_offset = '0;
            res.dest_offset   = '0;
            res.byte_count    = '0;
            res.in_range      = 1'b0;

            tile_cols   = ((luma_width() + 63) / 64 + 1) & ~64'd1;
            chroma_base = (tile_cols * ((luma_height() + 31) / 32) * 2048 + 8191) & ~64'd8191;
            pw          = plane_width(plane);
            ph          = plane_height(plane);
            stride      = plane ? chroma_stride : luma_stride;
            x           = chunk * 64;
            if (row >= ph || x >= pw)
                return res;

            // Tiles sit in pairs of tile rows; the odd row and all but a lone last
            // row are shifted by the zig-zag rule within each group of four.
            plane_tile_rows = (ph + 31) / 32;
            tx   = chunk;
            ty   = row / 32;
            tile = tx + (ty & ~64'd1) * tile_cols;
            if ((ty & 1) != 0)
                tile += (tx & ~64'd3) + 2;
            else if ((plane_tile_rows & 1) == 0 || ty + 1 != plane_tile_rows)
                tile += (tx + 2) & ~64'd3;

            src  = tile * 2048 + (row % 32) * 64 + (plane ? chroma_base : 0);
            dst  = row * stride + x;
            left = pw - x;

            res.source_offset = src[nv12d_pkg::OFFSET_W-1:0];
            res.dest_offset   = dst[nv12d_pkg::OFFSET_W-1:0];
            res.byte_count    = (left < 64) ? left[nv12d_pkg::COUNT_W-1:0]
                                            : nv12d_pkg::CHUNK_BYTES;
            res.in_range      = 1'b1;
            return res;
        endfunction

        function void note_request(logic plane, logic [nv12d_pkg::ROW_W-1:0] row,
                                   logic [nv12d_pkg::CHUNK_W-1:0] chunk);
            expected_q.push_back(chunk_address(plane, row, chunk));
        endfunction

        function void check_result(logic [nv12d_pkg::OFFSET_W-1:0] source_offset,
                                   logic [nv12d_pkg::OFFSET_W-1:0] dest_offset,
                                   logic [nv12d_pkg::COUNT_W-1:0] byte_count,
                                   logic in_range);
            chunk_result_t exp_res;

            if (expected_q.size() == 0) begin
                $error("result item arrived with no request outstanding");
                errors++;
                return;
            end
            exp_res = expected_q.pop_front();
            if (source_offset !== exp_res.source_offset) begin
                $error("source_offset mismatch: expected %0d, actual %0d",
                       exp_res.source_offset, source_offset);
                errors++;
            end
            if (dest_offset !== exp_res.dest_offset) begin
                $error("dest_offset mismatch: expected %0d, actual %0d",
                       exp_res.dest_offset, dest_offset);
                errors++;
            end
            if (byte_count !== exp_res.byte_count) begin
                $error("byte_count mismatch: expected %0d, actual %0d",
                       exp_res.byte_count, byte_count);
                errors++;
            end
            if (in_range !== exp_res.in_range) begin
                $error("in_range mismatch: expected %0d, actual %0d",
                       exp_res.in_range, in_range);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             cfg_we = 1'b0;
    logic [1:0]                       cfg_index = nv12d_pkg::CFG_FRAME_WIDTH;
    logic [nv12d_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [23:0]                      s_tdata = '0;  // row_index[11:0], chunk_index[17:12],
                                                     // zero pad
    logic                             s_tuser = 1'b0;  // plane_sel
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [63:0]                      m_tdata;  // source_offset[24:0], dest_offset[49:25],
                                                // byte_count[56:50], zero pad
    logic                             m_tuser;  // in_range

    chunk_scoreboard sb;
    int unsigned     idle_cycles = 0;
    int unsigned     rx_cycle = 0;
    int unsigned     rx_mode = 0;

    nv12_tiled_detile_address #(
        .MAX_WIDTH  (FRAME_MAX_W),
        .MAX_HEIGHT (FRAME_MAX_H)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #10 clk = ~clk;

    // The receiver switches at random between always ready, coin flips, heavy stalls
    // and a periodic pattern.
    always @(posedge clk)
    begin
        rx_cycle <= rx_cycle + 1;
        if (rx_cycle % 300 == 0)
            rx_mode <= $urandom_range(0, 3);
        case (rx_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            2: m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= ((rx_cycle / 7) % 3 != 0);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && sb != null) begin
            if (s_tvalid && s_tready)
                sb.note_request(s_tuser, s_tdata[11:0], s_tdata[17:12]);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata[24:0], m_tdata[49:25], m_tdata[56:50], m_tuser);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // Holds valid high until the item is taken; the caller lowers it for a gap.
    task automatic send_item(input logic plane, input int unsigned row, input int unsigned chunk);
        s_tvalid <= 1'b1;
        s_tuser  <= plane;
        s_tdata  <= {6'b0, chunk[nv12d_pkg::CHUNK_W-1:0], row[nv12d_pkg::ROW_W-1:0]};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic wait_results_done();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() > 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic put_reg(input nv12d_pkg::cfg_index_t idx,
                           input logic [nv12d_pkg::CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        sb.write_reg(idx, data);
    endtask

    task automatic write_frame_regs(input logic [nv12d_pkg::CFG_DATA_W-1:0] width,
                                    input logic [nv12d_pkg::CFG_DATA_W-1:0] height,
                                    input logic [nv12d_pkg::CFG_DATA_W-1:0] luma_stride,
                                    input logic [nv12d_pkg::CFG_DATA_W-1:0] chroma_stride);
        put_reg(nv12d_pkg::CFG_FRAME_WIDTH, width);
        put_reg(nv12d_pkg::CFG_FRAME_HEIGHT, height);
        put_reg(nv12d_pkg::CFG_LUMA_STRIDE, luma_stride);
        put_reg(nv12d_pkg::CFG_CHROMA_STRIDE, chroma_stride);
        cfg_we <= 1'b0;
    endtask

    // Mostly requests inside the plane, leaning on the last row and last chunk,
    // with some requests anywhere in the field ranges.
    task automatic run_requests(input int unsigned count);
        int unsigned sent;
        int unsigned burst;
        int unsigned pw;
        int unsigned ph;
        int unsigned last_chunk;
        int unsigned row;
        int unsigned chunk;
        logic        plane;

        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(1, 40);
            while (burst > 0 && sent < count) begin
                plane = 1'($urandom_range(0, 1));
                pw    = sb.plane_width(plane);
                ph    = sb.plane_height(plane);
                if (pw == 0 || ph == 0 || $urandom_range(0, 9) < 2) begin
                    row   = $urandom_range(0, 4095);
                    chunk = $urandom_range(0, 63);
                end else begin
                    last_chunk = (pw + 63) / 64 - 1;
                    if (last_chunk > 63)
                        last_chunk = 63;
                    row   = ($urandom_range(0, 4) == 0) ? ph - 1 : $urandom_range(0, ph - 1);
                    chunk = ($urandom_range(0, 4) == 0) ? last_chunk
                                                        : $urandom_range(0, last_chunk);
                end
                send_item(plane, row, chunk);
                burst--;
                sent++;
            end
            case ($urandom_range(0, 49))
                0: wait_results_done();
                1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12: ;
                default:
                begin
                    s_tvalid <= 1'b0;
                    repeat ($urandom_range(1, 12)) @(posedge clk);
                end
            endcase
        end
    endtask

    initial
    begin
        int unsigned w;
        int unsigned h;

        sb = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Registers at their reset values: one tile column pair, one tile row.
        send_item(1'b0, 0, 0);
        send_item(1'b0, 31, 0);
        send_item(1'b0, 32, 0);
        send_item(1'b0, 0, 1);
        send_item(1'b1, 15, 0);
        send_item(1'b1, 16, 0);
        send_item(1'b0, 4095, 63);
        wait_results_done();

        // Largest frame, with strides big enough that the destination offset wraps.
        write_frame_regs(4096, 4096, 16383, 8192);
        send_item(1'b0, 4095, 63);
        send_item(1'b0, 0, 63);
        send_item(1'b0, 33, 5);
        send_item(1'b1, 2047, 63);
        send_item(1'b1, 2048, 0);
        send_item(1'b1, 1000, 62);
        wait_results_done();

        // Three luma tile rows, so the lone last tile row is not zig-zagged.
        write_frame_regs(130, 96, 130, 8192);
        send_item(1'b0, 64, 0);
        send_item(1'b0, 64, 1);
        send_item(1'b0, 64, 2);
        send_item(1'b0, 95, 2);
        send_item(1'b0, 32, 3);
        send_item(1'b1, 47, 2);
        send_item(1'b1, 40, 1);
        send_item(1'b1, 48, 0);
        wait_results_done();

        for (int p = 0; p < PHASE_COUNT; p++) begin
            case (p)
                0: write_frame_regs(1, 1, 1, 1);
                1: write_frame_regs(0, 0, 5, 7);
                // Width of all ones exercises the dropped top data bit and the clamp.
                2: write_frame_regs(14'h3FFF, 8191, 16383, 16383);
                3: write_frame_regs(4096, 4096, 8192, 8192);
                4: write_frame_regs(129, 97, 200, 130);
                default:
                begin
                    w = $urandom_range(0, 1) ? $urandom_range(1, 512) : $urandom_range(1, 4096);
                    h = $urandom_range(0, 1) ? $urandom_range(1, 512) : $urandom_range(1, 4096);
                    write_frame_regs(14'(w), 14'(h), 14'($urandom_range(1, 16383)),
                                     14'($urandom_range(1, 16383)));
                end
            endcase
            run_requests(PHASE_ITEMS);
            wait_results_done();
        end

        repeat (10) @(posedge clk);
        if (sb.pending() != 0) begin
            $error("%0d expected results never arrived", sb.pending());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
